/* rtl/core/aes_pkg.sv */
package aes_pkg;

    localparam int RK_DEPTH_DEFAULT = 60;
    localparam int NR_MAX = 14;
    localparam int NK_MAX = 8;

    typedef enum logic [2:0] {
        REG_KEY_SIZE   = 3'd0,
        REG_KEY_WORD_0 = 3'd1,
        REG_KEY_WORD_1 = 3'd2,
        REG_KEY_WORD_2 = 3'd3,
        REG_KEY_WORD_3 = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2
    } key_size_t;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } blk_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } res_t;

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            sub_word[31-8*i -: 8] = SBOX_FWD[w[31-8*i -: 8]];
        end
    endfunction

    // byte n of the state sits at [127-8n -: 8]; column c is bytes 4c..4c+3
    function automatic logic [127:0] sub_fwd(input logic [127:0] s);
        for (int n = 0; n < 16; n++)
        begin
            sub_fwd[127-8*n -: 8] = SBOX_FWD[s[127-8*n -: 8]];
        end
    endfunction

    function automatic logic [127:0] sub_inv(input logic [127:0] s);
        for (int n = 0; n < 16; n++)
        begin
            sub_inv[127-8*n -: 8] = SBOX_INV[s[127-8*n -: 8]];
        end
    endfunction

    function automatic logic [127:0] shift_fwd(input logic [127:0] s);
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                shift_fwd[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
            end
        end
    endfunction

    function automatic logic [127:0] shift_inv(input logic [127:0] s);
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                shift_inv[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
            end
        end
    endfunction

    function automatic logic [127:0] mix_fwd(input logic [127:0] s);
        logic [7:0] a [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r] = s[127-8*(4*c+r) -: 8];
            end
            for (int r = 0; r < 4; r++)
            begin
                mix_fwd[127-8*(4*c+r) -: 8] = xtime(a[r]) ^ xtime(a[(r+1)%4]) ^ a[(r+1)%4]
                                              ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
    endfunction

    function automatic logic [127:0] mix_inv(input logic [127:0] s);
        logic [7:0] a  [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r]  = s[127-8*(4*c+r) -: 8];
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
            end
            // 0e, 0b, 0d, 09 along the row
            for (int r = 0; r < 4; r++)
            begin
                mix_inv[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
    endfunction

endpackage

/* rtl/core/aes_block_encrypt_decrypt_core.sv */
// Channel  Signals                          Direction  Beat
// blk      blk_valid/blk_ready/blk          in         cmd + 128-bit block
// res      res_valid/res_ready/res          out        128-bit result block
// cfg      cfg_valid/cfg_ready/cfg_index/   in         key size or 64-bit key word
//          cfg_wdata
//
// One block per cycle through 15 register stages (initial key add plus one round
// per stage), as long as no result stall or key schedule rebuild holds the input.
// After reset and after each key register write the key schedule is rebuilt one
// word per cycle (44, 52 or 60 words); blk_ready stays low meanwhile.
// Each stage holds when the one after it is full and stalled, so bubbles close up.
module aes_block_encrypt_decrypt_core #(
    parameter int ROUND_KEY_DEPTH = aes_pkg::RK_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          blk_valid,
    output logic          blk_ready,
    input  aes_pkg::blk_t blk,
    output logic          res_valid,
    input  logic          res_ready,
    output aes_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_wdata
);

    localparam int AW = $clog2(ROUND_KEY_DEPTH);
    localparam int CW = $clog2(ROUND_KEY_DEPTH + 1);
    localparam int NR_FIT = (ROUND_KEY_DEPTH >= 60) ? 14 : (ROUND_KEY_DEPTH >= 52) ? 12 : 10;
    localparam int NS = aes_pkg::NR_MAX + 1;

    // configuration
    logic [1:0]  key_size_reg;
    logic [63:0] key_reg [4];

    // key schedule
    logic [31:0]   rk_reg  [ROUND_KEY_DEPTH];
    logic [31:0]   win_reg [aes_pkg::NK_MAX];
    logic [CW-1:0] exp_cnt_reg;
    logic [2:0]    pos_reg;
    logic [7:0]    rc_reg;

    logic [3:0]  nr;
    logic [3:0]  nk;
    logic [5:0]  total;
    logic        busy;
    logic        is_load;
    logic [31:0] new_word;
    logic        use_rc;

    // pipeline
    logic [127:0] st_reg  [NS];
    logic         cmd_reg [NS];
    logic         vld_reg [NS];
    logic         rdy     [NS+1];
    logic [127:0] st_next [NS];
    logic [127:0] enc_key [NS];
    logic [127:0] dec_key [NS];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (key_size_reg)
            aes_pkg::KEY_128: nr = 4'd10;
            aes_pkg::KEY_192: nr = (NR_FIT >= 12) ? 4'd12 : 4'(NR_FIT);
            default:          nr = 4'(NR_FIT);
        endcase
        nk    = nr - 4'd6;
        total = {nr, 2'b00} + 6'd4;
    end

    assign busy    = (6'(exp_cnt_reg) < total);
    assign is_load = (6'(exp_cnt_reg) < 6'(nk));

    always_comb
    begin
        logic [31:0] t;
        logic [63:0] kw;
        kw     = key_reg[exp_cnt_reg[2:1]];
        t      = win_reg[3'(nk - 4'd1)];
        use_rc = 1'b0;
        if (pos_reg == 3'd0)
        begin
            t      = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_reg, 24'h0};
            use_rc = 1'b1;
        end
        else if (nk == 4'd8 && pos_reg == 3'd4)
        begin
            t = aes_pkg::sub_word(t);
        end
        if (is_load)
        begin
            new_word = exp_cnt_reg[0] ? kw[31:0] : kw[63:32];
        end
        else
        begin
            new_word = win_reg[0] ^ t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            exp_cnt_reg <= '0;
            pos_reg     <= 3'd0;
            rc_reg      <= 8'h01;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_SIZE:   key_size_reg <= cfg_wdata[1:0];
                aes_pkg::REG_KEY_WORD_0: key_reg[0]   <= cfg_wdata;
                aes_pkg::REG_KEY_WORD_1: key_reg[1]   <= cfg_wdata;
                aes_pkg::REG_KEY_WORD_2: key_reg[2]   <= cfg_wdata;
                aes_pkg::REG_KEY_WORD_3: key_reg[3]   <= cfg_wdata;
                default:                 ;
            endcase
            if (cfg_index <= aes_pkg::REG_KEY_WORD_3)
            begin
                exp_cnt_reg <= '0;
                pos_reg     <= 3'd0;
                rc_reg      <= 8'h01;
            end
        end
        else if (busy)
        begin
            exp_cnt_reg <= exp_cnt_reg + CW'(1);
            pos_reg     <= (4'(pos_reg) == nk - 4'd1) ? 3'd0 : pos_reg + 3'd1;
            if (!is_load && use_rc)
            begin
                rc_reg <= aes_pkg::xtime(rc_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy && !(cfg_valid && cfg_ready))
        begin
            rk_reg[exp_cnt_reg[AW-1:0]] <= new_word;
            for (int j = 0; j < aes_pkg::NK_MAX; j++)
            begin
                if (j == int'(nk) - 1)
                begin
                    win_reg[j] <= new_word;
                end
                else if (j < aes_pkg::NK_MAX - 1)
                begin
                    win_reg[j] <= win_reg[j+1];
                end
            end
        end
    end

    function automatic logic [127:0] rk_blk(input int base);
        for (int c = 0; c < 4; c++)
        begin
            if (base + c >= 0 && base + c < ROUND_KEY_DEPTH)
            begin
                rk_blk[127-32*c -: 32] = rk_reg[AW'(base + c)];
            end
            else
            begin
                rk_blk[127-32*c -: 32] = 32'h0;
            end
        end
    endfunction

    // stage k: encrypt uses round key k, decrypt uses round key nr-k
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            enc_key[k] = rk_blk(4 * k);
            case (nr)
                4'd10:   dec_key[k] = rk_blk(4 * (10 - k));
                4'd12:   dec_key[k] = rk_blk(4 * (12 - k));
                default: dec_key[k] = rk_blk(4 * (14 - k));
            endcase
        end
    end

    always_comb
    begin
        logic [127:0] x;
        st_next[0] = {blk.block_high, blk.block_low}
                     ^ ((blk.cmd == aes_pkg::CMD_DECRYPT) ? dec_key[0] : enc_key[0]);
        for (int k = 1; k < NS; k++)
        begin
            if (k > int'(nr))
            begin
                x = st_reg[k-1];
            end
            else if (cmd_reg[k-1] == aes_pkg::CMD_ENCRYPT)
            begin
                x = aes_pkg::shift_fwd(aes_pkg::sub_fwd(st_reg[k-1]));
                if (k != int'(nr))
                begin
                    x = aes_pkg::mix_fwd(x);
                end
                x = x ^ enc_key[k];
            end
            else
            begin
                x = st_reg[k-1];
                if (k != 1)
                begin
                    x = aes_pkg::mix_inv(x);
                end
                x = aes_pkg::sub_inv(aes_pkg::shift_inv(x)) ^ dec_key[k];
            end
            st_next[k] = x;
        end
    end

    always_comb
    begin
        rdy[NS] = res_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign blk_ready = rdy[0] && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= blk_valid && blk_ready;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_valid && blk_ready)
        begin
            st_reg[0]  <= st_next[0];
            cmd_reg[0] <= blk.cmd;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (rdy[k] && vld_reg[k-1])
            begin
                st_reg[k]  <= st_next[k];
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
    end

    assign res_valid    = vld_reg[NS-1];
    assign res.out_high = st_reg[NS-1][127:64];
    assign res.out_low  = st_reg[NS-1][63:0];

endmodule

/* sim/aes_cipher_checker.sv */
module aes_cipher_checker #(
    parameter int ROUND_KEY_DEPTH = aes_pkg::RK_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          blk_valid,
    input  logic          blk_ready,
    input  aes_pkg::blk_t blk,
    input  logic          res_valid,
    input  logic          res_ready,
    input  aes_pkg::res_t res,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_wdata,
    output int            fail_count,
    output int            pending,
    output int            checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]    key_sz;
    logic [63:0]   key_w [4];
    logic [31:0]   sched [ROUND_KEY_DEPTH];
    int            nrounds;
    aes_pkg::res_t cipher_q [$];

    function automatic logic [31:0] sbox_word(logic [31:0] w);
        logic [31:0] r;
        for (int i = 0; i < 4; i++)
        begin
            r[8*i +: 8] = aes_pkg::SBOX_FWD[w[8*i +: 8]];
        end
        return r;
    endfunction

    function void build_schedule();
        int          nr;
        int          nk;
        int          total;
        logic [31:0] rc;
        logic [31:0] t;
        logic [63:0] w;
        nr = (key_sz == aes_pkg::KEY_128) ? 10 : (key_sz == aes_pkg::KEY_192) ? 12 : 14;
        rc = 32'h0100_0000;
        // shrink key size if the schedule store is too shallow
        while (nr > 10 && 4 * (nr + 1) > ROUND_KEY_DEPTH)
        begin
            nr -= 2;
        end
        nk = nr - 6;
        total = 4 * (nr + 1);
        for (int i = 0; i < ROUND_KEY_DEPTH; i++)
        begin
            sched[i] = '0;
        end
        for (int i = 0; i < nk && i < ROUND_KEY_DEPTH; i++)
        begin
            w = key_w[(i >> 1) & 3];
            sched[i] = (i & 1) ? w[31:0] : w[63:32];
        end
        for (int i = nk; i < total && i < ROUND_KEY_DEPTH; i++)
        begin
            t = sched[i-1];
            if (i % nk == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ rc;
                rc = rc[31] ? ({rc[30:0], 1'b0} ^ 32'h1B00_0000) : {rc[30:0], 1'b0};
            end
            else if (nk > 6 && i % nk == 4)
            begin
                t = sbox_word(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
        nrounds = nr;
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
            b = b >> 1;
        end
        return p;
    endfunction

    function aes_pkg::res_t cipher_block(aes_pkg::blk_t b);
        logic [7:0]    s [16];
        logic [7:0]    t [16];
        logic [7:0]    m [4];
        logic [31:0]   w;
        aes_pkg::res_t r;
        int            rnd;
        int            src;
        for (int i = 0; i < 8; i++)
        begin
            s[i]   = b.block_high[63-8*i -: 8];
            s[i+8] = b.block_low[63-8*i -: 8];
        end
        if (b.cmd == aes_pkg::CMD_ENCRYPT)
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        else
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int k = 0; k <= nrounds; k++)
        begin
            rnd = (b.cmd == aes_pkg::CMD_ENCRYPT) ? k : nrounds - k;
            if (k > 0)
            begin
                if (b.cmd == aes_pkg::CMD_DECRYPT && k > 1)
                begin
                    for (int c = 0; c < 4; c++)
                        for (int j = 0; j < 4; j++)
                            t[4*c+j] = gmul(m[0], s[4*c+j]) ^ gmul(m[1], s[4*c+(j+1)%4])
                                     ^ gmul(m[2], s[4*c+(j+2)%4]) ^ gmul(m[3], s[4*c+(j+3)%4]);
                    s = t;
                end
                if (b.cmd == aes_pkg::CMD_ENCRYPT)
                begin
                    for (int i = 0; i < 16; i++)
                        s[i] = aes_pkg::SBOX_FWD[s[i]];
                end
                for (int j = 0; j < 4; j++)
                    for (int c = 0; c < 4; c++)
                    begin
                        src = j + 4 * ((c + j) % 4);
                        if (b.cmd == aes_pkg::CMD_ENCRYPT)
                            t[j+4*c] = s[src];
                        else
                            t[src] = s[j+4*c];
                    end
                s = t;
                if (b.cmd == aes_pkg::CMD_DECRYPT)
                begin
                    for (int i = 0; i < 16; i++)
                        s[i] = aes_pkg::SBOX_INV[s[i]];
                end
                if (b.cmd == aes_pkg::CMD_ENCRYPT && k != nrounds)
                begin
                    for (int c = 0; c < 4; c++)
                        for (int j = 0; j < 4; j++)
                            t[4*c+j] = gmul(m[0], s[4*c+j]) ^ gmul(m[1], s[4*c+(j+1)%4])
                                     ^ gmul(m[2], s[4*c+(j+2)%4]) ^ gmul(m[3], s[4*c+(j+3)%4]);
                    s = t;
                end
            end
            for (int c = 0; c < 4; c++)
            begin
                w = (4 * rnd + c < ROUND_KEY_DEPTH) ? sched[4*rnd+c] : '0;
                for (int j = 0; j < 4; j++)
                    s[4*c+j] ^= w[31-8*j -: 8];
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            r.out_high[63-8*i -: 8] = s[i];
            r.out_low[63-8*i -: 8]  = s[i+8];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        aes_pkg::res_t want;
        if (!rst_n)
        begin
            key_sz = aes_pkg::KEY_128;
            for (int i = 0; i < 4; i++)
                key_w[i] = '0;
            build_schedule();
            cipher_q.delete();
            fail_count <= 0;
            checked <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (cipher_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing pending: %h", $realtime, res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    checked <= checked + 1;
                    if (want.out_high !== res.out_high || want.out_low !== res.out_low)
                    begin
                        if (fail_count < 10)
                            $display("%0t: result exp %h_%h got %h_%h", $realtime,
                                     want.out_high, want.out_low, res.out_high, res.out_low);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (blk_valid && blk_ready)
                cipher_q.push_back(cipher_block(blk));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    aes_pkg::REG_KEY_SIZE:   key_sz = cfg_wdata[1:0];
                    aes_pkg::REG_KEY_WORD_0: key_w[0] = cfg_wdata;
                    aes_pkg::REG_KEY_WORD_1: key_w[1] = cfg_wdata;
                    aes_pkg::REG_KEY_WORD_2: key_w[2] = cfg_wdata;
                    aes_pkg::REG_KEY_WORD_3: key_w[3] = cfg_wdata;
                    default: ;
                endcase
                if (cfg_index <= aes_pkg::REG_KEY_WORD_3)
                    build_schedule();
            end
            pending <= cipher_q.size();
        end
    end
endmodule

/* sim/tb_aes_block_encrypt_decrypt_core.sv */
module tb_aes_block_encrypt_decrypt_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_SPARE = 3'd5;  // first index past the key registers
    localparam int LIMIT = 600000;

    logic          clk;
    logic          rst_n;
    logic          blk_valid;
    logic          blk_ready;
    aes_pkg::blk_t blk;
    logic          res_valid;
    logic          res_ready;
    aes_pkg::res_t res;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [63:0]   cfg_wdata;
    int            fail_count;
    int            pending;
    int            checked;
    int            cycles;
    int            key_settings;
    int            stall_left;
    bit            steady;

    aes_block_encrypt_decrypt_core dut (
        .clk(clk), .rst_n(rst_n),
        .blk_valid(blk_valid), .blk_ready(blk_ready), .blk(blk),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    aes_cipher_checker chk (
        .clk(clk), .rst_n(rst_n),
        .blk_valid(blk_valid), .blk_ready(blk_ready), .blk(blk),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("aes_block_encrypt_decrypt_core: mismatch");
            $finish;
        end
    end

    // result-side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            res_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_blk(logic c, logic [63:0] hi, logic [63:0] lo);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            blk_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        blk_valid <= 1'b1;
        blk <= '{cmd: c, block_high: hi, block_low: lo};
        @(negedge clk);
        while (!blk_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // only reconfigure once the pipeline has drained
    task automatic load_key(logic [1:0] sz, logic [63:0] k0, logic [63:0] k1,
                            logic [63:0] k2, logic [63:0] k3);
        blk_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        write_reg(aes_pkg::REG_KEY_WORD_0, k0);
        write_reg(aes_pkg::REG_KEY_WORD_1, k1);
        write_reg(aes_pkg::REG_KEY_WORD_2, k2);
        write_reg(aes_pkg::REG_KEY_WORD_3, k3);
        write_reg(REG_SPARE + 3'($urandom_range(0, 2)), {$urandom, $urandom});
        write_reg(aes_pkg::REG_KEY_SIZE, {62'($urandom), sz});
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    task automatic directed_blocks();
        send_blk(aes_pkg::CMD_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        send_blk(aes_pkg::CMD_DECRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        send_blk(aes_pkg::CMD_ENCRYPT, '0, '0);
        send_blk(aes_pkg::CMD_DECRYPT, '1, '1);
    endtask

    initial
    begin
        logic [63:0] r [4];
        cycles = 0;
        key_settings = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        blk_valid = 1'b0;
        blk = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero key from reset, then the standard test keys at every size
        directed_blocks();
        load_key(aes_pkg::KEY_128, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                 '1, '1);
        directed_blocks();
        send_blk(aes_pkg::CMD_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
        load_key(aes_pkg::KEY_192, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                 64'h1011_1213_1415_1617, '0);
        directed_blocks();
        load_key(aes_pkg::KEY_256, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                 64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f);
        directed_blocks();
        // size code three behaves as a 256-bit key
        load_key(2'd3, '1, '1, '1, '1);
        directed_blocks();

        for (int ph = 0; ph < 14; ph++)
        begin
            for (int i = 0; i < 4; i++)
                r[i] = {$urandom, $urandom};
            load_key(2'($urandom_range(0, 3)), r[0], r[1], r[2], r[3]);
            steady = (ph % 4 == 3);
            for (int n = 0; n < 62; n++)
                send_blk(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
            steady = 1'b0;
        end
        blk_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("%0d blocks checked over %0d key settings, 128/192/256-bit and size code 3,",
                 checked, key_settings + 1);
        $display("encrypt and decrypt with random gaps and result stalls");
        if (fail_count == 0 && pending == 0)
            $display("aes_block_encrypt_decrypt_core: match");
        else
            $display("aes_block_encrypt_decrypt_core: mismatch");
        $finish;
    end
endmodule

/* aes_block_encrypt_decrypt_core.f */
rtl/core/aes_pkg.sv
rtl/core/aes_block_encrypt_decrypt_core.sv
sim/aes_cipher_checker.sv
sim/tb_aes_block_encrypt_decrypt_core.sv
